// File: hdl/multipart_delimiter_scanner_defines.svh
// assertion macros for the multipart delimiter scanner
// used by the top level only, no other dependencies
`ifndef MULTIPART_DELIMITER_SCANNER_DEFINES_SVH
`define MULTIPART_DELIMITER_SCANNER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MDS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/mds_pkg.sv
// shared types, constants and marker helpers for the multipart delimiter scanner
// no dependencies
package mds_pkg;

  localparam int MARKER_MAX   = 80;
  localparam int BOUNDARY_MAX = 70;
  localparam int PREFIX_LEN   = 4;
  localparam int MARKER_EXTRA = 6;

  // longest usable boundary
  localparam int BOUNDARY_LIM =
    (MARKER_MAX - MARKER_EXTRA < BOUNDARY_MAX) ? (MARKER_MAX - MARKER_EXTRA) : BOUNDARY_MAX;

  localparam int CNT_W     = $clog2(MARKER_MAX + 1);
  localparam int WIN_IDX_W = $clog2(MARKER_MAX);
  localparam int ST_IDX_W  = $clog2(BOUNDARY_MAX);

  localparam int OP_W    = 2;
  localparam int INDEX_W = 7;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 7;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  localparam logic [BYTE_W-1:0] DASH = 8'h2D;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] boundary_index;
    logic [BYTE_W-1:0]  in_byte;
  } mds_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  payload_byte;
    logic               delimiter_found;
    logic [COUNT_W-1:0] payload_count;
  } mds_out_t;

  typedef struct packed {
    logic load_store;
    logic start_scan;
    logic append;
    logic evaluate;
    logic emit;
  } mds_cmd_t;

  typedef struct packed {
    logic scan_active;
    logic full;
    logic match;
  } mds_status_t;

  // CR LF - - ahead of the boundary
  function automatic logic [BYTE_W-1:0] lead_byte(input int pos);
    logic [BYTE_W-1:0] b;
    unique case (pos)
      0:       b = 8'h0D;
      1:       b = 8'h0A;
      default: b = DASH;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/mds_ctrl.sv
// controller for the multipart delimiter scanner: sequences accept, compare and result load
// depends on mds_pkg
module mds_ctrl
  import mds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [OP_W-1:0] in_op,
  output logic        out_valid,
  input  logic        out_ready,
  input  mds_status_t status,
  output mds_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_op == OP_LOAD) begin
            cmd.load_store = 1'b1;
          end else if (in_op == OP_START) begin
            cmd.start_scan = 1'b1;
          end else if (in_op == OP_DATA && status.scan_active) begin
            cmd.append = 1'b1;
            state_next = ST_EVAL;
          end else begin
            // unused op, or data while no scan runs
          end
        end
      end
      ST_EVAL: begin
        if (status.full) begin
          cmd.evaluate = 1'b1;
          state_next   = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/mds_datapath.sv
// datapath for the multipart delimiter scanner: boundary store, hold window,
// parallel marker compare, release counter and result register; depends on mds_pkg
module mds_datapath
  import mds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  boundary_length,
  input  mds_in_t           in_data,
  input  mds_cmd_t          cmd,
  output mds_status_t       status,
  output mds_out_t          out_data
);

  logic [BYTE_W-1:0]    boundary_store [BOUNDARY_MAX];
  logic [BYTE_W-1:0]    hold_window [MARKER_MAX];
  logic [CNT_W-1:0]     hold_count;
  logic [COUNT_W-1:0]   released_total;
  logic                 scan_active;
  logic                 match_q;

  logic [CNT_W-1:0]     blen;
  logic [CNT_W-1:0]     mlen;
  logic [CNT_W-1:0]     bnd_end;
  logic [WIN_IDX_W-1:0] wr_idx;
  logic [MARKER_MAX-1:0] pos_ok;
  logic [COUNT_W-1:0]   total_inc;

  // zero acts as one, long values saturate
  always_comb begin
    if (boundary_length == '0) begin
      blen = CNT_W'(1);
    end else if (int'(boundary_length) > BOUNDARY_LIM) begin
      blen = CNT_W'(BOUNDARY_LIM);
    end else begin
      blen = CNT_W'(boundary_length);
    end
  end

  assign mlen    = blen + CNT_W'(MARKER_EXTRA);
  assign bnd_end = blen + CNT_W'(PREFIX_LEN);
  assign wr_idx  = (int'(hold_count) >= MARKER_MAX) ? WIN_IDX_W'(MARKER_MAX - 1)
                                                     : hold_count[WIN_IDX_W-1:0];
  assign total_inc = (released_total == '1) ? released_total : released_total + COUNT_W'(1);

  // one comparator per window position
  for (genvar i = 0; i < MARKER_MAX; i++) begin : g_cmp
    logic [BYTE_W-1:0] expect_byte;
    if (i < PREFIX_LEN) begin : g_lead
      assign expect_byte = lead_byte(i);
    end else if (i < PREFIX_LEN + BOUNDARY_MAX) begin : g_bnd
      assign expect_byte = (CNT_W'(i) < bnd_end) ? boundary_store[i - PREFIX_LEN] : DASH;
    end else begin : g_tail
      assign expect_byte = DASH;
    end
    assign pos_ok[i] = (CNT_W'(i) >= mlen) || (hold_window[i] == expect_byte);
  end

  assign status.scan_active = scan_active;
  assign status.full        = (hold_count >= mlen);
  assign status.match       = match_q;

  always_ff @(posedge clk) begin
    if (cmd.load_store && int'(in_data.boundary_index) < BOUNDARY_MAX) begin
      boundary_store[ST_IDX_W'(in_data.boundary_index)] <= in_data.in_byte;
    end
    if (cmd.evaluate) begin
      match_q <= &pos_ok;
    end
  end

  // hold window: append at the fill point, shift out the oldest on release
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      hold_window[wr_idx] <= in_data.in_byte;
    end else if (cmd.emit && !match_q) begin
      for (int i = 0; i < MARKER_MAX - 1; i++) begin
        hold_window[i] <= hold_window[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (match_q) begin
        out_data.payload_byte    <= '0;
        out_data.delimiter_found <= 1'b1;
        out_data.payload_count   <= released_total;
      end else begin
        out_data.payload_byte    <= hold_window[0];
        out_data.delimiter_found <= 1'b0;
        out_data.payload_count   <= total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count     <= '0;
      released_total <= '0;
      scan_active    <= 1'b0;
    end else begin
      if (cmd.start_scan) begin
        hold_count     <= '0;
        released_total <= '0;
        scan_active    <= 1'b1;
      end else if (cmd.append) begin
        hold_count <= (int'(hold_count) >= MARKER_MAX) ? CNT_W'(MARKER_MAX)
                                                       : hold_count + CNT_W'(1);
      end else if (cmd.emit) begin
        if (match_q) begin
          hold_count  <= '0;
          scan_active <= 1'b0;
        end else begin
          hold_count     <= hold_count - CNT_W'(1);
          released_total <= total_inc;
        end
      end
    end
  end

endmodule

// File: hdl/multipart_delimiter_scanner.sv
// Multipart closing-delimiter scanner. Load boundary characters with op 0, start a body
// with op 2, then feed body bytes with op 1; each byte that brings the held count to the marker
// length (usable boundary length + 6 bytes, CR LF -- boundary --) releases the oldest held byte with a
// saturating running count, and a full match gives one delimiter result and ends the body.
// Loads, starts and ignored items are handled in ST_IDLE alone; a data byte during a scan
// passes through accept and a full-window check, and once the hold window is full also through
// a parallel window compare into a register and a result load that waits for the output
// register to be taken. boundary_length is written through the cfg channel, which is always ready.
// Depends on mds_pkg, mds_ctrl, mds_datapath and multipart_delimiter_scanner_defines.svh.
`include "multipart_delimiter_scanner_defines.svh"

module multipart_delimiter_scanner
  import mds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mds_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mds_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] boundary_length;
  mds_cmd_t         cmd;
  mds_status_t      status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_length <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      boundary_length <= cfg_data;
    end
  end

  mds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mds_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .boundary_length (boundary_length),
    .in_data         (in_data),
    .cmd             (cmd),
    .status          (status),
    .out_data        (out_data)
  );

  // a matched delimiter closes the scan
  `MDS_ASSERT_NEXT(a_match_ends_scan, clk, rst, cmd.emit && status.match, !status.scan_active, "scan still active after delimiter")
  // a result only ever comes from a full hold window
  `MDS_ASSERT_NOW(a_emit_needs_full, clk, rst, cmd.emit, status.full, "result from a partly filled window")
  // an accepted data byte during a scan keeps the input side busy while it is compared
  `MDS_ASSERT_NEXT(a_data_busy, clk, rst, in_valid && in_ready && in_data.op == OP_DATA && status.scan_active, !in_ready, "input accepted during compare")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// testbench for multipart_delimiter_scanner: directed and random multipart bodies,
// each result checked against an in-bench model of the hold window and marker match
// depends on mds_pkg and the scanner rtl
module tb_top;
  import mds_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] CR = 8'h0D;
  localparam logic [BYTE_W-1:0] LF = 8'h0A;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_GOAL = 950;
  localparam int unsigned SHOW_MAX = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mds_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mds_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  multipart_delimiter_scanner u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // scanner model state
  logic [BYTE_W-1:0] bnd_chars [BOUNDARY_MAX];
  logic [BYTE_W-1:0] held_bytes [MARKER_MAX];
  int unsigned held_cnt = 0;
  logic [COUNT_W-1:0] released_cnt = '0;
  bit scanning = 1'b0;
  logic [CFG_W-1:0] bnd_len_reg = 7'd1;

  mds_in_t body_items_q [$];
  mds_out_t scan_results_q [$];

  // stimulus side view of the boundary store
  logic [BYTE_W-1:0] gen_chars [BOUNDARY_MAX];
  bit gen_loaded [BOUNDARY_MAX] = '{default: 1'b0};
  int unsigned gen_blen = 1;
  bit gen_open = 1'b0;
  int unsigned items_made = 0;
  int unsigned len_writes = 0;

  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned delims_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  mds_out_t want;

  function automatic int unsigned usable_len(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > BOUNDARY_LIM) return BOUNDARY_LIM;
    return 32'(v);
  endfunction

  function automatic logic [BYTE_W-1:0] marker_at(int unsigned pos, int unsigned blen);
    if (pos == 0) return CR;
    if (pos == 1) return LF;
    if (pos < PREFIX_LEN) return DASH;
    if (pos < PREFIX_LEN + blen) return bnd_chars[pos - PREFIX_LEN];
    return DASH;
  endfunction

  function automatic void scanner_step(mds_in_t it);
    int unsigned blen;
    int unsigned mlen;
    int unsigned i;
    bit hit;
    mds_out_t res;
    case (it.op)
      OP_LOAD: begin
        if (it.boundary_index < BOUNDARY_MAX) bnd_chars[it.boundary_index] = it.in_byte;
      end
      OP_START: begin
        held_cnt = 0;
        released_cnt = '0;
        scanning = 1'b1;
      end
      OP_DATA: begin
        if (scanning) begin
          blen = usable_len(bnd_len_reg);
          mlen = blen + MARKER_EXTRA;
          if (held_cnt >= MARKER_MAX) held_cnt = MARKER_MAX - 1;
          held_bytes[held_cnt] = it.in_byte;
          held_cnt++;
          if (held_cnt >= mlen) begin
            // after a shrink only the oldest marker-length bytes take part
            hit = 1'b1;
            for (i = 0; i < mlen; i++) begin
              if (held_bytes[i] != marker_at(i, blen)) hit = 1'b0;
            end
            if (hit) begin
              held_cnt = 0;
              scanning = 1'b0;
              res.payload_byte = '0;
              res.delimiter_found = 1'b1;
              res.payload_count = released_cnt;
            end else begin
              res.payload_byte = held_bytes[0];
              for (i = 0; i + 1 < held_cnt; i++) held_bytes[i] = held_bytes[i + 1];
              held_cnt--;
              if (released_cnt != '1) released_cnt++;
              res.delimiter_found = 1'b0;
              res.payload_count = released_cnt;
            end
            scan_results_q.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scanner_step(in_data);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (body_items_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (in_idle_on && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          in_data <= body_items_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (scan_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("unexpected transaction: byte %02h delim %0b count %0d",
                     out_data.payload_byte, out_data.delimiter_found, out_data.payload_count);
        end else begin
          want = scan_results_q.pop_front();
          if (want.delimiter_found) delims_seen++;
          if (out_data.payload_byte !== want.payload_byte ||
              out_data.delimiter_found !== want.delimiter_found ||
              out_data.payload_count !== want.payload_count) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display("mismatch: want byte %02h delim %0b count %0d, got %02h %0b %0d",
                       want.payload_byte, want.delimiter_found, want.payload_count,
                       out_data.payload_byte, out_data.delimiter_found,
                       out_data.payload_count);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycles, scan_results_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void push_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                    logic [BYTE_W-1:0] b, bit counted);
    mds_in_t it;
    it.op = op;
    it.boundary_index = idx;
    it.in_byte = b;
    body_items_q.push_back(it);
    if (counted) items_made++;
    if (op == OP_LOAD && idx < BOUNDARY_MAX) begin
      gen_chars[idx] = b;
      gen_loaded[idx] = 1'b1;
    end
  endfunction

  // every boundary entry the marker can touch must be written before data arrives
  function automatic void load_missing();
    int unsigned i;
    for (i = 0; i < gen_blen; i++) begin
      if (!gen_loaded[i])
        push_item(OP_LOAD, INDEX_W'(i), BYTE_W'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  function automatic void push_data(logic [BYTE_W-1:0] b);
    push_item(OP_DATA, INDEX_W'($urandom_range(0, 127)), b, 1'b1);
  endfunction

  function automatic void push_lead_and_boundary();
    int unsigned i;
    push_data(CR);
    push_data(LF);
    push_data(DASH);
    push_data(DASH);
    for (i = 0; i < gen_blen; i++) push_data(gen_chars[i]);
  endfunction

  function automatic void push_closing();
    push_lead_and_boundary();
    push_data(DASH);
    push_data(DASH);
    gen_open = 1'b0;
  endfunction

  function automatic void push_start();
    push_item(OP_START, INDEX_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 255)),
              1'b1);
    gen_open = 1'b1;
  endfunction

  // biased towards marker characters so partial matches are common
  function automatic logic [BYTE_W-1:0] body_byte();
    case ($urandom_range(0, 5))
      0: return CR;
      1: return LF;
      2: return DASH;
      3: return gen_chars[$urandom_range(0, gen_blen - 1)];
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void fill_body(int unsigned n);
    int unsigned i;
    logic [BYTE_W-1:0] b;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: begin
          // inner part boundary without the closing dashes
          push_lead_and_boundary();
          b = BYTE_W'($urandom_range(0, 255));
          push_data(b == DASH ? CR : b);
        end
        1: push_item(OP_UNUSED, INDEX_W'($urandom_range(0, 127)),
                     BYTE_W'($urandom_range(0, 255)), 1'b0);
        2: push_item(OP_LOAD, INDEX_W'($urandom_range(BOUNDARY_MAX, 127)),
                     BYTE_W'($urandom_range(0, 255)), 1'b0);
        3: push_item(OP_LOAD, INDEX_W'($urandom_range(0, BOUNDARY_MAX - 1)),
                     BYTE_W'($urandom_range(0, 255)), 1'b1);
        default: push_data(body_byte());
      endcase
    end
  endfunction

  task automatic settle();
    do @(posedge clk);
    while (body_items_q.size() != 0 || in_valid || scan_results_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    bnd_len_reg = v;
    gen_blen = usable_len(v);
    len_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned k;
    int unsigned seqs;
    logic [CFG_W-1:0] v;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero length acts as one, ignored items, two short bodies
    write_length(7'd0);
    push_item(OP_LOAD, 7'd0, 8'h00, 1'b1);
    push_item(OP_LOAD, 7'd69, 8'h80, 1'b1);
    push_item(OP_LOAD, 7'd127, 8'hFF, 1'b0);
    push_item(OP_UNUSED, 7'd85, 8'hAA, 1'b0);
    push_item(OP_DATA, 7'd42, 8'hFF, 1'b0);
    push_start();
    push_data(8'hFF);
    push_data(8'h00);
    push_closing();
    push_data(8'h7F);
    push_start();
    push_closing();
    settle();

    // longest boundary, reached by saturation and then exactly
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    write_length(7'd127);
    load_missing();
    push_start();
    fill_body(12);
    push_closing();
    settle();
    write_length(CFG_W'(BOUNDARY_MAX));
    push_start();
    push_lead_and_boundary();
    push_data(8'h41);
    push_closing();
    settle();

    // shrink the length while bytes are still held
    write_length(7'd20);
    push_start();
    for (k = 0; k < 30; k++) push_data(BYTE_W'($urandom_range(0, 255)));
    settle();
    write_length(7'd2);
    fill_body(6);
    push_closing();
    settle();

    while (items_made < ITEM_GOAL) begin
      if (items_made > ITEM_GOAL * 85 / 100) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      case ($urandom_range(0, 19))
        0: v = 7'd0;
        1: v = CFG_W'($urandom_range(BOUNDARY_MAX + 1, 127));
        2: v = CFG_W'(BOUNDARY_MAX);
        3, 4: v = CFG_W'($urandom_range(9, BOUNDARY_MAX - 1));
        default: v = CFG_W'($urandom_range(1, 8));
      endcase
      write_length(v);
      load_missing();
      seqs = $urandom_range(1, 3);
      for (k = 0; k < seqs; k++) begin
        // an open scan may carry on under the new length
        if (!gen_open || $urandom_range(0, 3) != 0) push_start();
        fill_body($urandom_range(0, 20));
        if ($urandom_range(0, 6) != 0) begin
          push_closing();
          if ($urandom_range(0, 3) == 0) push_data(BYTE_W'($urandom_range(0, 255)));
        end
      end
      settle();
    end

    $display("scanner run: %0d items sent, %0d results checked, %0d closing delimiters",
             items_sent, results_seen, delims_seen);
    $display("%0d length writes, %0d mismatches, %0d results outstanding",
             len_writes, mismatches, scan_results_q.size());
    if (mismatches == 0 && scan_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
